[rtl/assert_macros.svh]
// Assertion macros used by the top-level RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define CHK_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed");
`define CHK_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed");
`endif

[rtl/htu_pkg.sv]
// Package: types, constants and fixed-point helpers for the transform unit
`default_nettype none
package htu_pkg;
    localparam int FRAC_BITS = 16;
    localparam int WORD_BITS = 32;

    typedef enum logic [2:0] {
        OP_IDENT   = 3'd0,
        OP_WR_CUR  = 3'd1,
        OP_WR_STG  = 3'd2,
        OP_TRANS   = 3'd3,
        OP_SCALE   = 3'd4,
        OP_COMPOSE = 3'd5,
        OP_APPLY3  = 3'd6,
        OP_APPLY2  = 3'd7
    } op_t;

    typedef logic signed [WORD_BITS-1:0] word_t;

    typedef struct packed {
        logic [2:0]         opcode;
        logic [3:0]         entry_index;
        logic signed [31:0] value_x;
        logic signed [31:0] value_y;
        logic signed [31:0] value_z;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic               w_was_zero;
    } out_item_t;

    localparam word_t WMAX = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam word_t WMIN = {1'b1, {(WORD_BITS-1){1'b0}}};
    localparam word_t ONE  = word_t'(1 << FRAC_BITS);

    function automatic word_t sadd(input word_t a, input word_t b);
        logic signed [WORD_BITS:0] s;
        s = {a[WORD_BITS-1], a} + {b[WORD_BITS-1], b};
        if (s[WORD_BITS] != s[WORD_BITS-1])
            return s[WORD_BITS] ? WMIN : WMAX;
        return s[WORD_BITS-1:0];
    endfunction

    function automatic word_t sat_prod(input logic signed [2*WORD_BITS-1:0] p);
        logic signed [2*WORD_BITS-1:0] q;
        logic signed [2*WORD_BITS-1:0] lim_hi;
        logic signed [2*WORD_BITS-1:0] lim_lo;
        q = (p < 0) ? -((-p) >>> FRAC_BITS) : (p >>> FRAC_BITS);
        lim_hi = {{WORD_BITS{1'b0}}, WMAX};
        lim_lo = {{WORD_BITS{1'b1}}, WMIN};
        if (q > lim_hi) return WMAX;
        if (q < lim_lo) return WMIN;
        return q[WORD_BITS-1:0];
    endfunction

    function automatic logic signed [31:0] to_out(input word_t v);
        return v;
    endfunction
endpackage
`default_nettype wire

[rtl/htu_div.sv]
// Serial restoring divider: (n << FRAC_BITS) / d, truncated and saturated
`default_nettype none
module htu_div (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    input  wire htu_pkg::word_t num,
    input  wire htu_pkg::word_t den,
    output logic                done,
    output htu_pkg::word_t      quo
);
    localparam int NB = htu_pkg::WORD_BITS + htu_pkg::FRAC_BITS;
    localparam int CW = $clog2(NB + 1);

    logic [NB-1:0]                  dvd_reg;
    logic [htu_pkg::WORD_BITS:0]    rem_reg;
    logic [htu_pkg::WORD_BITS:0]    dsr_reg;
    logic [NB-1:0]                  q_reg;
    logic [CW-1:0]                  cnt_reg;
    logic                           neg_reg;
    logic                           busy_reg;
    logic [htu_pkg::WORD_BITS:0]    rem_sh;
    logic [htu_pkg::WORD_BITS:0]    nmag;
    logic [htu_pkg::WORD_BITS:0]    dmag;
    logic [NB-1:0]                  lim;

    assign nmag = num[htu_pkg::WORD_BITS-1] ? -{num[htu_pkg::WORD_BITS-1], num}
                                           : {1'b0, num};
    assign dmag = den[htu_pkg::WORD_BITS-1] ? -{den[htu_pkg::WORD_BITS-1], den}
                                           : {1'b0, den};
    assign rem_sh = {rem_reg[htu_pkg::WORD_BITS-1:0], dvd_reg[NB-1]};
    assign lim = NB'(htu_pkg::WMAX);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done     <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(NB);
                dvd_reg  <= {nmag[htu_pkg::WORD_BITS-1:0], {htu_pkg::FRAC_BITS{1'b0}}};
                rem_reg  <= '0;
                q_reg    <= '0;
                dsr_reg  <= dmag;
                neg_reg  <= num[htu_pkg::WORD_BITS-1] ^ den[htu_pkg::WORD_BITS-1];
            end
            else if (busy_reg)
            begin
                dvd_reg <= dvd_reg << 1;
                if (rem_sh >= dsr_reg)
                begin
                    rem_reg <= rem_sh - dsr_reg;
                    q_reg   <= {q_reg[NB-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem_sh;
                    q_reg   <= {q_reg[NB-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        if (q_reg > lim)
            quo = neg_reg ? htu_pkg::WMIN : htu_pkg::WMAX;
        else
            quo = neg_reg ? -htu_pkg::word_t'(q_reg) : htu_pkg::word_t'(q_reg);
    end
endmodule
`default_nettype wire

[rtl/homogeneous_transform_unit_top.sv]
// Top level: matrix memories, shared multiply-accumulate sequencer, divider
// Apply 3D and apply 2D return a result beat; when w is zero the divides are skipped.
// Throughput: one operation at a time; writes take a beat every cycle, the sequencer
// walks the products one after another and the divides run one after another.
// Reset: asynchronous active low; an initialization pass loads identity into both matrices.
`default_nettype none
`include "assert_macros.svh"
module homogeneous_transform_unit_top (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire htu_pkg::in_item_t  in_data,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output htu_pkg::out_item_t      out_data
);
    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_RD, S_MUL, S_ACC, S_WB, S_DIV, S_DIVW, S_OUT
    } state_t;

    htu_pkg::word_t cur_mem [16];
    htu_pkg::word_t stg_mem [16];
    htu_pkg::word_t cur_rd_reg, stg_rd_reg;
    htu_pkg::word_t res_mem [4];

    state_t state_reg;
    htu_pkg::in_item_t op_reg;
    logic [3:0] init_reg;
    logic [1:0] r_reg, c_reg, k_reg;
    logic [1:0] div_reg;
    htu_pkg::word_t acc_reg;
    logic signed [2*htu_pkg::WORD_BITS-1:0] prod_reg;
    htu_pkg::word_t w_reg;
    htu_pkg::word_t tmp_reg [16];
    logic out_valid_reg;
    htu_pkg::out_item_t out_reg;
    htu_pkg::out_item_t pt_reg;

    logic [3:0] cur_addr, stg_addr;
    htu_pkg::word_t opnd;
    htu_pkg::word_t vsel [3];
    logic [1:0] nk;
    logic div_start, div_done;
    htu_pkg::word_t div_q, div_num;
    logic is_apply;
    logic wb_en;

    assign vsel[0] = htu_pkg::word_t'(op_reg.value_x);
    assign vsel[1] = htu_pkg::word_t'(op_reg.value_y);
    assign vsel[2] = htu_pkg::word_t'(op_reg.value_z);
    assign is_apply = op_reg.opcode == htu_pkg::OP_APPLY3 ||
                      op_reg.opcode == htu_pkg::OP_APPLY2;

    always_comb
    begin
        cur_addr = {k_reg, r_reg};
        stg_addr = {c_reg, k_reg};
        nk = 2'd3;
        case (op_reg.opcode)
            htu_pkg::OP_TRANS:   nk = 2'd3;
            htu_pkg::OP_SCALE:   cur_addr = {c_reg, r_reg};
            htu_pkg::OP_APPLY2:  nk = 2'd2;
            default:             nk = 2'd3;
        endcase
        if (is_apply && k_reg == nk)
            cur_addr = {2'd3, r_reg};
        if (op_reg.opcode == htu_pkg::OP_TRANS && k_reg == 2'd3)
            cur_addr = {2'd3, r_reg};
    end

    always_comb
    begin
        opnd = vsel[k_reg == 2'd3 ? 2'd0 : k_reg];
        case (op_reg.opcode)
            htu_pkg::OP_SCALE:   opnd = vsel[c_reg == 2'd3 ? 2'd0 : c_reg];
            htu_pkg::OP_COMPOSE: opnd = stg_rd_reg;
            default:             opnd = vsel[k_reg == 2'd3 ? 2'd0 : k_reg];
        endcase
    end

    always_comb
    begin
        case (op_reg.opcode)
            htu_pkg::OP_TRANS: wb_en = init_reg[3:2] == 2'd3;
            htu_pkg::OP_SCALE: wb_en = init_reg[3:2] != 2'd3;
            default:           wb_en = 1'b1;
        endcase
    end

    always_ff @(posedge clk)
    begin
        cur_rd_reg <= cur_mem[cur_addr];
        stg_rd_reg <= stg_mem[stg_addr];
    end

    assign div_num = res_mem[div_reg];
    assign div_start = state_reg == S_DIV;

    htu_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (w_reg),
        .done  (div_done),
        .quo   (div_q)
    );

    always_ff @(posedge clk)
    begin
        if (state_reg == S_INIT)
        begin
            cur_mem[init_reg] <= (init_reg[1:0] == init_reg[3:2]) ? htu_pkg::ONE : '0;
            stg_mem[init_reg] <= (init_reg[1:0] == init_reg[3:2]) ? htu_pkg::ONE : '0;
        end
        else if (state_reg == S_IDLE && in_valid)
        begin
            if (in_data.opcode == htu_pkg::OP_WR_STG)
                stg_mem[in_data.entry_index] <= htu_pkg::word_t'(in_data.value_x);
        end
        if (state_reg == S_WB && wb_en)
            cur_mem[init_reg] <= tmp_reg[init_reg];
        else if (state_reg == S_IDLE && in_valid)
        begin
            if (in_data.opcode == htu_pkg::OP_WR_CUR)
                cur_mem[in_data.entry_index] <= htu_pkg::word_t'(in_data.value_x);
        end
        else if (op_reg.opcode == htu_pkg::OP_IDENT && state_reg == S_RD)
            cur_mem[init_reg] <= (init_reg[1:0] == init_reg[3:2]) ? htu_pkg::ONE : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            init_reg      <= '0;
            r_reg         <= '0;
            c_reg         <= '0;
            k_reg         <= '0;
            div_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !out_stall && state_reg != S_OUT)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_INIT:
                begin
                    init_reg <= init_reg + 1'b1;
                    if (init_reg == 4'd15)
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        op_reg   <= in_data;
                        r_reg    <= '0;
                        c_reg    <= '0;
                        k_reg    <= (in_data.opcode == htu_pkg::OP_TRANS) ? 2'd3 : 2'd0;
                        init_reg <= '0;
                        acc_reg  <= '0;
                        if (in_data.opcode == htu_pkg::OP_WR_CUR ||
                            in_data.opcode == htu_pkg::OP_WR_STG)
                            state_reg <= S_IDLE;
                        else
                            state_reg <= S_RD;
                    end
                end
                S_RD:
                begin
                    if (op_reg.opcode == htu_pkg::OP_IDENT)
                    begin
                        init_reg <= init_reg + 1'b1;
                        if (init_reg == 4'd15)
                            state_reg <= S_IDLE;
                    end
                    else
                        state_reg <= S_MUL;
                end
                S_MUL:
                begin
                    prod_reg <= (2*htu_pkg::WORD_BITS)'(cur_rd_reg) * opnd;
                    state_reg <= S_ACC;
                end
                S_ACC:
                begin
                    state_reg <= S_RD;
                    case (op_reg.opcode)
                        htu_pkg::OP_SCALE:
                        begin
                            tmp_reg[{c_reg, r_reg}] <= htu_pkg::sat_prod(prod_reg);
                            r_reg <= r_reg + 1'b1;
                            if (r_reg == 2'd3)
                            begin
                                c_reg <= c_reg + 1'b1;
                                if (c_reg == 2'd2)
                                    state_reg <= S_WB;
                            end
                        end
                        htu_pkg::OP_TRANS:
                        begin
                            if (k_reg == 2'd3)
                            begin
                                acc_reg <= cur_rd_reg;
                                k_reg   <= 2'd0;
                            end
                            else
                            begin
                                acc_reg <= htu_pkg::sadd(acc_reg, htu_pkg::sat_prod(prod_reg));
                                if (k_reg == 2'd2)
                                begin
                                    tmp_reg[{2'd3, r_reg}] <=
                                        htu_pkg::sadd(acc_reg, htu_pkg::sat_prod(prod_reg));
                                    k_reg <= 2'd3;
                                    r_reg <= r_reg + 1'b1;
                                    if (r_reg == 2'd3)
                                        state_reg <= S_WB;
                                end
                                else
                                    k_reg <= k_reg + 1'b1;
                            end
                        end
                        htu_pkg::OP_COMPOSE:
                        begin
                            k_reg <= k_reg + 1'b1;
                            if (k_reg == 2'd3)
                            begin
                                tmp_reg[{c_reg, r_reg}] <=
                                    htu_pkg::sadd(acc_reg, htu_pkg::sat_prod(prod_reg));
                                acc_reg <= '0;
                                r_reg <= r_reg + 1'b1;
                                if (r_reg == 2'd3)
                                begin
                                    c_reg <= c_reg + 1'b1;
                                    if (c_reg == 2'd3)
                                        state_reg <= S_WB;
                                end
                            end
                            else
                                acc_reg <= htu_pkg::sadd(acc_reg, htu_pkg::sat_prod(prod_reg));
                        end
                        default:
                        begin
                            if (k_reg == nk)
                            begin
                                res_mem[r_reg] <= htu_pkg::sadd(acc_reg, cur_rd_reg);
                                acc_reg <= '0;
                                k_reg   <= '0;
                                r_reg   <= r_reg + 1'b1;
                                if (r_reg == 2'd3)
                                begin
                                    w_reg     <= htu_pkg::sadd(acc_reg, cur_rd_reg);
                                    div_reg   <= '0;
                                    state_reg <= S_DIV;
                                end
                            end
                            else
                            begin
                                acc_reg <= htu_pkg::sadd(acc_reg, htu_pkg::sat_prod(prod_reg));
                                k_reg   <= k_reg + 1'b1;
                            end
                        end
                    endcase
                end
                S_WB:
                begin
                    init_reg <= init_reg + 1'b1;
                    if (init_reg == 4'd15)
                        state_reg <= S_IDLE;
                end
                S_DIV:
                begin
                    if (w_reg == '0)
                    begin
                        pt_reg    <= '{out_x: '0, out_y: '0, out_z: '0, w_was_zero: 1'b1};
                        state_reg <= S_OUT;
                    end
                    else
                        state_reg <= S_DIVW;
                end
                S_DIVW:
                begin
                    if (div_done)
                    begin
                        pt_reg.w_was_zero <= 1'b0;
                        case (div_reg)
                            2'd0: pt_reg.out_x <= htu_pkg::to_out(div_q);
                            2'd1:
                            begin
                                pt_reg.out_y <= htu_pkg::to_out(div_q);
                                pt_reg.out_z <= '0;
                            end
                            default: pt_reg.out_z <= htu_pkg::to_out(div_q);
                        endcase
                        if (div_reg == 2'd2 ||
                            (div_reg == 2'd1 && op_reg.opcode == htu_pkg::OP_APPLY2))
                            state_reg <= S_OUT;
                        else
                        begin
                            div_reg   <= div_reg + 1'b1;
                            state_reg <= S_DIV;
                        end
                    end
                end
                S_OUT:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_reg       <= pt_reg;
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign in_stall  = state_reg != S_IDLE;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    `CHK_IMPL(a_no_take_busy, in_valid && !in_stall, state_reg == S_IDLE)
    `CHK_NEXT(a_out_hold, out_valid && out_stall, out_valid)
    `CHK_IMPL(a_zero_flag, out_valid && out_data.w_was_zero, out_data.out_x == 32'sd0)
endmodule
`default_nettype wire

[tb/homogeneous_transform_unit_checker.sv]
`timescale 1ns / 1ps
// Checker for the transform unit: predicts each point result and compares it with the output beat
module homogeneous_transform_unit_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  htu_pkg::in_item_t  in_data,
    input  logic               out_valid,
    input  logic               out_stall,
    input  htu_pkg::out_item_t out_data,
    output int                 error_count,
    output int                 pending_count
);
    localparam longint QMAX = 64'sd2147483647;
    localparam longint QMIN = -64'sd2147483648;

    longint             cur_m[16];
    longint             stg_m[16];
    htu_pkg::out_item_t point_queue[$];

    function automatic longint clamp_q(input longint v);
        if (v > QMAX)
            return QMAX;
        if (v < QMIN)
            return QMIN;
        return v;
    endfunction

    function automatic longint add_sat(input longint a, input longint b);
        return clamp_q(a + b);
    endfunction

    function automatic longint mul_q(input longint a, input longint b);
        longint p;
        longint m;
        p = a * b;
        m = (p < 0) ? -p : p;
        m = m >>> htu_pkg::FRAC_BITS;
        return clamp_q((p < 0) ? -m : m);
    endfunction

    function automatic longint div_q(input longint n, input longint d);
        longint un;
        longint ud;
        longint q;
        un = (n < 0) ? -n : n;
        ud = (d < 0) ? -d : d;
        q = (un <<< htu_pkg::FRAC_BITS) / ud;
        return clamp_q(((n < 0) != (d < 0)) ? -q : q);
    endfunction

    task automatic load_identity(inout longint m[16]);
        for (int i = 0; i < 16; i++)
            m[i] = (i % 5 == 0) ? longint'(1 << htu_pkg::FRAC_BITS) : 0;
    endtask

    task automatic transform_step(input htu_pkg::in_item_t it);
        longint v[3];
        longint old[16];
        longint res[4];
        longint acc;
        int     nterms;
        htu_pkg::op_t    op;
        htu_pkg::out_item_t o;
        op = htu_pkg::op_t'(it.opcode);
        v[0] = longint'(it.value_x);
        v[1] = longint'(it.value_y);
        v[2] = longint'(it.value_z);
        case (op)
            htu_pkg::OP_IDENT:
                load_identity(cur_m);
            htu_pkg::OP_WR_CUR:
                cur_m[it.entry_index] = v[0];
            htu_pkg::OP_WR_STG:
                stg_m[it.entry_index] = v[0];
            htu_pkg::OP_TRANS:
                for (int r = 0; r < 4; r++)
                begin
                    acc = cur_m[12 + r];
                    for (int k = 0; k < 3; k++)
                        acc = add_sat(acc, mul_q(v[k], cur_m[k * 4 + r]));
                    cur_m[12 + r] = acc;
                end
            htu_pkg::OP_SCALE:
                for (int c = 0; c < 3; c++)
                    for (int r = 0; r < 4; r++)
                        cur_m[c * 4 + r] = mul_q(cur_m[c * 4 + r], v[c]);
            htu_pkg::OP_COMPOSE:
            begin
                old = cur_m;
                for (int c = 0; c < 4; c++)
                    for (int r = 0; r < 4; r++)
                    begin
                        acc = 0;
                        for (int k = 0; k < 4; k++)
                            acc = add_sat(acc, mul_q(old[k * 4 + r], stg_m[c * 4 + k]));
                        cur_m[c * 4 + r] = acc;
                    end
            end
            default:
            begin
                nterms = (op == htu_pkg::OP_APPLY3) ? 3 : 2;
                for (int r = 0; r < 4; r++)
                begin
                    acc = 0;
                    for (int k = 0; k < nterms; k++)
                        acc = add_sat(acc, mul_q(cur_m[k * 4 + r], v[k]));
                    res[r] = add_sat(acc, cur_m[12 + r]);
                end
                o = '0;
                if (res[3] == 0)
                    o.w_was_zero = 1'b1;
                else
                begin
                    o.out_x = 32'(div_q(res[0], res[3]));
                    o.out_y = 32'(div_q(res[1], res[3]));
                    o.out_z = (op == htu_pkg::OP_APPLY3) ? 32'(div_q(res[2], res[3])) : '0;
                end
                point_queue.push_back(o);
            end
        endcase
    endtask

    initial
    begin
        error_count = 0;
        load_identity(cur_m);
        load_identity(stg_m);
    end

    always @(posedge clk)
    begin
        htu_pkg::out_item_t want;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                transform_step(in_data);
            if (out_valid && !out_stall)
            begin
                if (point_queue.size() == 0)
                begin
                    error_count++;
                    $display("%0t: unexpected result beat %h", $time, out_data);
                end
                else
                begin
                    want = point_queue.pop_front();
                    if (want.out_x !== out_data.out_x || want.out_y !== out_data.out_y
                        || want.out_z !== out_data.out_z
                        || want.w_was_zero !== out_data.w_was_zero)
                    begin
                        error_count++;
                        $display("%0t: mismatch expected x=%h y=%h z=%h wz=%b actual x=%h y=%h z=%h wz=%b",
                                 $time, want.out_x, want.out_y, want.out_z, want.w_was_zero,
                                 out_data.out_x, out_data.out_y, out_data.out_z,
                                 out_data.w_was_zero);
                    end
                end
            end
        end
        pending_count = point_queue.size();
    end
endmodule

[tb/homogeneous_transform_unit_top_tb.sv]
`timescale 1ns / 1ps
// Testbench top: drives operation beats into the transform unit and reports the verdict
module homogeneous_transform_unit_top_tb;
    localparam int QUIET_LIMIT = 4000;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    htu_pkg::in_item_t  in_data;
    logic               out_valid;
    logic               out_stall;
    htu_pkg::out_item_t out_data;
    int                 error_count;
    int                 pending_count;
    int                 send_idle_pct;
    int                 recv_idle_pct;
    int                 quiet_cycles;

    homogeneous_transform_unit_top i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data (out_data)
    );

    homogeneous_transform_unit_checker i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .in_data      (in_data),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_data     (out_data),
        .error_count  (error_count),
        .pending_count(pending_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(negedge clk)
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic logic signed [31:0] rand_value();
        case ($urandom_range(0, 9))
            0: return $urandom;
            1: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
            2: return 32'sh00010000;
            default: return $signed(32'($urandom_range(0, 1048575))) - 32'sd524288;
        endcase
    endfunction

    function automatic htu_pkg::in_item_t make_item(input htu_pkg::op_t op,
                                                    input logic [3:0] idx,
                                                    input logic signed [31:0] x,
                                                    input logic signed [31:0] y,
                                                    input logic signed [31:0] z);
        htu_pkg::in_item_t it;
        it.opcode = op;
        it.entry_index = idx;
        it.value_x = x;
        it.value_y = y;
        it.value_z = z;
        return it;
    endfunction

    function automatic htu_pkg::in_item_t random_item();
        htu_pkg::op_t op;
        int  pick;
        pick = $urandom_range(0, 99);
        if (pick < 30)
            op = htu_pkg::OP_APPLY3;
        else if (pick < 45)
            op = htu_pkg::OP_APPLY2;
        else if (pick < 65)
            op = htu_pkg::OP_WR_CUR;
        else if (pick < 75)
            op = htu_pkg::OP_WR_STG;
        else if (pick < 83)
            op = htu_pkg::OP_TRANS;
        else if (pick < 91)
            op = htu_pkg::OP_SCALE;
        else if (pick < 96)
            op = htu_pkg::OP_COMPOSE;
        else
            op = htu_pkg::OP_IDENT;
        return make_item(op, 4'($urandom_range(0, 15)), rand_value(), rand_value(),
                         rand_value());
    endfunction

    task automatic send_beat(input htu_pkg::in_item_t it);
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        in_valid = 1'b1;
        in_data = it;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    initial
    begin
        in_valid = 1'b0;
        in_data = '0;
        send_idle_pct = 19;
        recv_idle_pct = 55;
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_beat(make_item(htu_pkg::OP_APPLY3, 4'd0, 32'sh00010000, 32'sh00020000,
                            32'sh00030000));
        send_beat(make_item(htu_pkg::OP_APPLY2, 4'd0, 32'sh7fffffff, 32'sh80000000,
                            32'sh7fffffff));
        send_beat(make_item(htu_pkg::OP_WR_CUR, 4'd0, 32'sh7fffffff, 32'shffffffff, 32'sh0));
        send_beat(make_item(htu_pkg::OP_WR_CUR, 4'd15, 32'sh80000000, 32'sh0, 32'shffffffff));
        send_beat(make_item(htu_pkg::OP_APPLY3, 4'd15, 32'sh7fffffff, 32'sh7fffffff,
                            32'sh80000000));
        send_beat(make_item(htu_pkg::OP_WR_CUR, 4'd15, 32'sh0, 32'sh0, 32'sh0));
        send_beat(make_item(htu_pkg::OP_APPLY3, 4'd0, 32'sh00050000, 32'sh0, 32'sh0));
        send_beat(make_item(htu_pkg::OP_APPLY2, 4'd0, 32'sh00050000, 32'sh0, 32'sh0));
        send_beat(make_item(htu_pkg::OP_IDENT, 4'd7, 32'sh12345678, 32'sh9abcdef0, 32'sh0));
        send_beat(make_item(htu_pkg::OP_TRANS, 4'd0, 32'sh00018000, 32'shfffe0000,
                            32'sh7fffffff));
        send_beat(make_item(htu_pkg::OP_APPLY3, 4'd0, 32'sh00010000, 32'sh00010000,
                            32'sh00010000));
        send_beat(make_item(htu_pkg::OP_SCALE, 4'd0, 32'sh00020000, 32'sh80000000,
                            32'sh00008000));
        send_beat(make_item(htu_pkg::OP_APPLY3, 4'd0, 32'sh00010000, 32'sh00010000,
                            32'sh00010000));
        send_beat(make_item(htu_pkg::OP_WR_STG, 4'd0, 32'sh00020000, 32'sh0, 32'sh0));
        send_beat(make_item(htu_pkg::OP_WR_STG, 4'd15, 32'sh00030000, 32'sh0, 32'sh0));
        send_beat(make_item(htu_pkg::OP_WR_STG, 4'd12, 32'sh7fffffff, 32'sh0, 32'sh0));
        send_beat(make_item(htu_pkg::OP_COMPOSE, 4'd3, 32'sh0, 32'sh0, 32'sh0));
        send_beat(make_item(htu_pkg::OP_APPLY3, 4'd0, 32'sh00010000, 32'shffff0000, 32'sh0));
        send_beat(make_item(htu_pkg::OP_WR_CUR, 4'd15, 32'sh00000001, 32'sh0, 32'sh0));
        send_beat(make_item(htu_pkg::OP_APPLY2, 4'd0, 32'sh7fffffff, 32'sh7fffffff,
                            32'sh12345678));
        send_beat(make_item(htu_pkg::OP_IDENT, 4'd0, 32'sh0, 32'sh0, 32'sh0));

        for (int n = 0; n < 1300; n++)
        begin
            if (n == 433)
            begin
                send_idle_pct = 55;
                recv_idle_pct = 19;
            end
            else if (n == 866)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if ($urandom_range(0, 39) == 0)
                send_beat(make_item(htu_pkg::OP_IDENT, 4'($urandom), $urandom, $urandom,
                                    $urandom));
            else
                send_beat(random_item());
        end

        while (pending_count != 0)
            @(posedge clk);
        repeat (250) @(posedge clk);
        if (error_count == 0 && pending_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
